// File: hdl/pwlcm_pkg.sv
package pwlcm_pkg;

    // Maximum gradient stops in use; the register packing always has four slots.
    localparam int NUM_STOPS  = 4;
    localparam int SLOT_IDX_W = 2;
    localparam int COUNT_W    = 3;

    localparam int POS_W      = 16;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int COLOR_W    = CH_W * NUM_CH;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    // Span of two stops and the weighted sum of two channel values.
    localparam int SPAN_W     = POS_W;
    localparam int NUM_W      = SPAN_W + CH_W;

    // Quotient bits resolved in each divider stage.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = CH_W / DIV_BITS;

    // Select, span, multiply, the divider stages and the output register.
    localparam int DIV_BASE   = 3;
    localparam int STAGES     = DIV_BASE + DIV_STAGES + 1;
    localparam int OUT_STAGE  = STAGES - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT     = 2'd0,
        REG_STOP_POSITIONS = 2'd1,
        REG_COLORS_LOW     = 2'd2,
        REG_COLORS_HIGH    = 2'd3
    } t_cfg_idx;

    function automatic logic signed [POS_W-1:0] stop_pos(
        input logic [CFG_W-1:0]      positions,
        input logic [SLOT_IDX_W-1:0] k
    );
        return positions[POS_W*k +: POS_W];
    endfunction

    function automatic logic [COLOR_W-1:0] stop_color(
        input logic [CFG_W-1:0]      colors_low,
        input logic [CFG_W-1:0]      colors_high,
        input logic [SLOT_IDX_W-1:0] k
    );
        logic [CFG_W-1:0] word;
        word = k[1] ? colors_high : colors_low;
        return word[COLOR_W*k[0] +: COLOR_W];
    endfunction

endpackage

// File: hdl/pwlcm_in_if.sv
interface pwlcm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pwlcm_pkg::POS_W-1:0]   position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

// File: hdl/pwlcm_out_if.sv
interface pwlcm_out_if;
    logic                           valid;
    logic                           ready;
    logic [pwlcm_pkg::CH_W-1:0]     red;
    logic [pwlcm_pkg::CH_W-1:0]     green;
    logic [pwlcm_pkg::CH_W-1:0]     blue;
    logic [pwlcm_pkg::CH_W-1:0]     alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

// File: hdl/piecewise_linear_color_map.sv
// Throughput: one item per cycle unless o_out.ready stalls the output; eight register
// stages, the divider resolving two quotient bits per stage, each stage advancing on
// its own so bubbles close up.
// Reset (synchronous, active low) empties the pipeline and clears all four registers,
// giving zero stops and black output.
module piecewise_linear_color_map (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pwlcm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pwlcm_pkg::CFG_W-1:0]        i_cfg_data,
    pwlcm_in_if.sink                           i_in,
    pwlcm_out_if.source                        o_out
);

    localparam int POS_W    = pwlcm_pkg::POS_W;
    localparam int CH_W     = pwlcm_pkg::CH_W;
    localparam int NUM_CH   = pwlcm_pkg::NUM_CH;
    localparam int COLOR_W  = pwlcm_pkg::COLOR_W;
    localparam int CFG_W    = pwlcm_pkg::CFG_W;
    localparam int COUNT_W  = pwlcm_pkg::COUNT_W;
    localparam int SLOT_W   = pwlcm_pkg::SLOT_IDX_W;
    localparam int SPAN_W   = pwlcm_pkg::SPAN_W;
    localparam int NUM_W    = pwlcm_pkg::NUM_W;
    localparam int DIV_BITS = pwlcm_pkg::DIV_BITS;
    localparam int DIV_ST   = pwlcm_pkg::DIV_STAGES;
    localparam int DIV_BASE = pwlcm_pkg::DIV_BASE;
    localparam int STAGES   = pwlcm_pkg::STAGES;
    localparam int OUT_ST   = pwlcm_pkg::OUT_STAGE;

    // Configuration registers.
    logic [COUNT_W-1:0] r_stop_count;
    logic [CFG_W-1:0]   r_stop_positions;
    logic [CFG_W-1:0]   r_colors_low;
    logic [CFG_W-1:0]   r_colors_high;

    logic [STAGES-1:0]  r_valid;
    logic [STAGES-1:0]  adv;

    // Stage 1: segment select.
    logic                      r1_lerp;
    logic signed [POS_W-1:0]   r1_t, r1_p0, r1_p1;
    logic [COLOR_W-1:0]        r1_c0, r1_c1;
    logic                      n1_lerp;
    logic signed [POS_W-1:0]   n1_p0, n1_p1;
    logic [COLOR_W-1:0]        n1_c0, n1_c1;

    // Stage 2: distances.
    logic                      r2_lerp;
    logic [SPAN_W-1:0]         r2_span, r2_below, r2_above;
    logic [COLOR_W-1:0]        r2_c0, r2_c1;
    logic [SPAN_W:0]           n2_span, n2_below, n2_above;

    // Stage 3: weighted sums.
    logic                      r3_lerp;
    logic [SPAN_W-1:0]         r3_span;
    logic [COLOR_W-1:0]        r3_color;
    logic [NUM_W-1:0]          r3_num [NUM_CH];
    logic [NUM_W-1:0]          n3_num [NUM_CH];

    // Divider stages.
    logic                      r_dv_lerp  [DIV_ST];
    logic [SPAN_W-1:0]         r_dv_span  [DIV_ST];
    logic [COLOR_W-1:0]        r_dv_color [DIV_ST];
    logic [NUM_W-1:0]          r_dv_rem   [DIV_ST][NUM_CH];
    logic [CH_W-1:0]           r_dv_q     [DIV_ST][NUM_CH];
    logic [NUM_W-1:0]          n_dv_rem   [DIV_ST][NUM_CH];
    logic [CH_W-1:0]           n_dv_q     [DIV_ST][NUM_CH];

    // Output register.
    logic [COLOR_W-1:0]        r_out_color;
    logic [COLOR_W-1:0]        n_out_color;

    // A stage takes new contents when it is empty or its own contents move on.
    always_comb begin
        adv[OUT_ST] = !r_valid[OUT_ST] || o_out.ready;
        for (int k = OUT_ST - 1; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign i_in.ready  = adv[0];
    assign o_out.valid = r_valid[OUT_ST];
    assign o_out.red   = r_out_color[0*CH_W +: CH_W];
    assign o_out.green = r_out_color[1*CH_W +: CH_W];
    assign o_out.blue  = r_out_color[2*CH_W +: CH_W];
    assign o_out.alpha = r_out_color[3*CH_W +: CH_W];

    // Find the first stop in use whose position lies above the input.
    always_comb begin
        logic [COUNT_W-1:0] n;
        logic [COUNT_W-1:0] sel;
        logic [COUNT_W-1:0] sel_m1;
        logic [COUNT_W-1:0] last;
        n = r_stop_count;
        if (r_stop_count > COUNT_W'(pwlcm_pkg::NUM_STOPS)) begin
            n = COUNT_W'(pwlcm_pkg::NUM_STOPS);
        end
        sel = n;
        for (int k = pwlcm_pkg::NUM_STOPS - 1; k >= 0; k--) begin
            if ((COUNT_W'(k) < n) &&
                (pwlcm_pkg::stop_pos(r_stop_positions, SLOT_W'(k)) > i_in.position)) begin
                sel = COUNT_W'(k);
            end
        end
        sel_m1 = sel - COUNT_W'(1);
        last   = n - COUNT_W'(1);
        n1_lerp = 1'b0;
        n1_p0   = pwlcm_pkg::stop_pos(r_stop_positions, sel_m1[SLOT_W-1:0]);
        n1_p1   = pwlcm_pkg::stop_pos(r_stop_positions, sel[SLOT_W-1:0]);
        n1_c1   = pwlcm_pkg::stop_color(r_colors_low, r_colors_high, sel[SLOT_W-1:0]);
        if (n == '0) begin
            n1_c0 = '0;
        end else if (sel == n) begin
            n1_c0 = pwlcm_pkg::stop_color(r_colors_low, r_colors_high, last[SLOT_W-1:0]);
        end else if (sel == '0) begin
            n1_c0 = pwlcm_pkg::stop_color(r_colors_low, r_colors_high, SLOT_W'(0));
        end else begin
            n1_lerp = 1'b1;
            n1_c0   = pwlcm_pkg::stop_color(r_colors_low, r_colors_high,
                                            sel_m1[SLOT_W-1:0]);
        end
    end

    // Both operands lie in the signed 16-bit range, so 17 bits hold each difference.
    always_comb begin
        n2_span  = (SPAN_W+1)'(r1_p1) - (SPAN_W+1)'(r1_p0);
        n2_below = (SPAN_W+1)'(r1_t)  - (SPAN_W+1)'(r1_p0);
        n2_above = (SPAN_W+1)'(r1_p1) - (SPAN_W+1)'(r1_t);
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n3_num[ch] = NUM_W'(r2_c0[ch*CH_W +: CH_W]) * NUM_W'(r2_above)
                       + NUM_W'(r2_c1[ch*CH_W +: CH_W]) * NUM_W'(r2_below);
        end
    end

    // Restoring division; the sum never reaches 256 spans, so eight quotient bits do.
    always_comb begin
        logic [NUM_W-1:0]  rem;
        logic [CH_W-1:0]   q;
        logic [NUM_W-1:0]  dvs;
        logic [SPAN_W-1:0] sp;
        for (int j = 0; j < DIV_ST; j++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (j == 0) begin
                    rem = r3_num[ch];
                    q   = '0;
                    sp  = r3_span;
                end else begin
                    rem = r_dv_rem[j-1][ch];
                    q   = r_dv_q[j-1][ch];
                    sp  = r_dv_span[j-1];
                end
                for (int b = 0; b < DIV_BITS; b++) begin
                    dvs = NUM_W'(sp) << (CH_W - 1 - j * DIV_BITS - b);
                    if (rem >= dvs) begin
                        rem = rem - dvs;
                        q   = q | (CH_W'(1) << (CH_W - 1 - j * DIV_BITS - b));
                    end
                end
                n_dv_rem[j][ch] = rem;
                n_dv_q[j][ch]   = q;
            end
        end
    end

    always_comb begin
        n_out_color = r_dv_color[DIV_ST-1];
        if (r_dv_lerp[DIV_ST-1]) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                n_out_color[ch*CH_W +: CH_W] = r_dv_q[DIV_ST-1][ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count     <= '0;
            r_stop_positions <= '0;
            r_colors_low     <= '0;
            r_colors_high    <= '0;
        end else if (i_cfg_we) begin
            unique case (pwlcm_pkg::t_cfg_idx'(i_cfg_idx))
                pwlcm_pkg::REG_STOP_COUNT:     r_stop_count     <= i_cfg_data[COUNT_W-1:0];
                pwlcm_pkg::REG_STOP_POSITIONS: r_stop_positions <= i_cfg_data;
                pwlcm_pkg::REG_COLORS_LOW:     r_colors_low     <= i_cfg_data;
                pwlcm_pkg::REG_COLORS_HIGH:    r_colors_high    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= (k == 0) ? i_in.valid : r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_lerp <= n1_lerp;
            r1_t    <= i_in.position;
            r1_p0   <= n1_p0;
            r1_p1   <= n1_p1;
            r1_c0   <= n1_c0;
            r1_c1   <= n1_c1;
        end
        if (adv[1]) begin
            r2_lerp  <= r1_lerp;
            r2_span  <= n2_span[SPAN_W-1:0];
            r2_below <= n2_below[SPAN_W-1:0];
            r2_above <= n2_above[SPAN_W-1:0];
            r2_c0    <= r1_c0;
            r2_c1    <= r1_c1;
        end
        if (adv[2]) begin
            r3_lerp  <= r2_lerp;
            r3_span  <= r2_span;
            r3_color <= r2_c0;
            r3_num   <= n3_num;
        end
        for (int j = 0; j < DIV_ST; j++) begin
            if (adv[DIV_BASE + j]) begin
                r_dv_lerp[j]  <= (j == 0) ? r3_lerp  : r_dv_lerp[j-1];
                r_dv_span[j]  <= (j == 0) ? r3_span  : r_dv_span[j-1];
                r_dv_color[j] <= (j == 0) ? r3_color : r_dv_color[j-1];
                r_dv_rem[j]   <= n_dv_rem[j];
                r_dv_q[j]     <= n_dv_q[j];
            end
        end
        if (adv[OUT_ST]) begin
            r_out_color <= n_out_color;
        end
    end

endmodule
